@@ sv/bti_pkg.sv @@
// ----------------------------------------------------------------------------
// bti_pkg - shared definitions for the breakpoint table interpolator
// Types, register indexes, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bti_pkg;

	localparam int DEF_ENTRIES = 32;
	localparam int DEF_TABLES  = 3;

	localparam int XY_W    = 16;
	localparam int VALUE_W = 17;
	localparam int CFG_W   = 17;
	localparam int CNT_W   = 6;
	localparam int CIDX_W  = 3;
	localparam int SEL_W   = 2;
	localparam int EIDX_W  = 5;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_MODEL_VALID     = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_TORQUE_OVERRIDE = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_MAG_COUNT       = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_TIME_COUNT      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_TORQUE_COUNT    = 3'd4;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_WRITE  = 1'b1;

	localparam logic [SEL_W-1:0] SEL_MAG    = 2'd0;
	localparam logic [SEL_W-1:0] SEL_TIME   = 2'd1;
	localparam logic [SEL_W-1:0] SEL_TORQUE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN,
		ST_DIVGO,
		ST_DIVRUN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [XY_W-1:0] dy;
		logic [XY_W-1:0] dx;
		logic [XY_W-1:0] span;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [XY_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ sv/bti_mem.sv @@
// ----------------------------------------------------------------------------
// bti_mem - breakpoint store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bti_mem #(
	parameter int DEPTH  = bti_pkg::DEF_TABLES * bti_pkg::DEF_ENTRIES,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic [2*bti_pkg::XY_W-1:0]     wdata,
	input  logic [ADDR_W-1:0]              raddr,
	output logic [2*bti_pkg::XY_W-1:0]     rdata
);

	logic [2*bti_pkg::XY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/bti_div.sv @@
// ----------------------------------------------------------------------------
// bti_div - scaled segment quotient
// Computes (dy * dx) / span: the product is registered on start, then one
// restoring step a cycle. Requires dx < span, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module bti_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bti_pkg::div_req_t   req,
	output bti_pkg::div_rsp_t   rsp
);

	localparam int W = bti_pkg::XY_W;

	logic [2*W-1:0]       prod;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         low_q;
	logic [W-1:0]         span_q;
	logic [$clog2(W):0]   cnt_q;
	logic                 busy_q;
	logic [W:0]           trial;
	logic                 fits;

	assign prod  = req.dy * req.dx;
	assign trial = {rem_q, low_q[W-1]};
	assign fits  = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ($clog2(W)+1)'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ($clog2(W)+1)'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= prod[2*W-1:W];
			low_q  <= prod[W-1:0];
			span_q <= req.span;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, span_q}) : trial[W-1:0];
			low_q <= {low_q[W-2:0], fits};
		end
	end

	// done on the final step (counter at one); the last quotient bit is combinational
	assign rsp.done = busy_q && (cnt_q == ($clog2(W)+1)'(1));
	assign rsp.quot = {low_q[W-2:0], fits};

endmodule

@@ sv/breakpoint_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator - piecewise-linear breakpoint tables
// Holds several (x, y) tables; loads entries and returns interpolated values.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one transaction: func
//   selects an entry write or a lookup of table_sel at query_x. Each request
//   gives exactly one response on rsp_valid / rsp_stall carrying value
//   (zero for writes).
//   A write, a lookup on an unused table, an override or a lookup with no
//   model answers on the cycle after acceptance. A real lookup scans the
//   table one breakpoint a cycle through the single store read port (up to
//   the breakpoint count) and then runs a multiply and restoring divide
//   for the segment quotient.
//   One request is in flight at a time; req_stall is high from acceptance
//   until the response is taken, and the next request can be taken in the
//   cycle after that.
//   Reset clears the sequencer and configuration (no model, no override,
//   counts of one); the table store is not cleared and must be written
//   before it is read. A stalled response holds its value until taken.
//   The user must write configuration via cfg_we / cfg_index / cfg_data
//   only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator #(
	parameter int ENTRIES = bti_pkg::DEF_ENTRIES,
	parameter int TABLES  = bti_pkg::DEF_TABLES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bti_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [bti_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          func,
	input  logic [bti_pkg::SEL_W-1:0]     table_sel,
	input  logic [bti_pkg::EIDX_W-1:0]    entry_index,
	input  logic [bti_pkg::XY_W-1:0]      entry_x,
	input  logic [bti_pkg::XY_W-1:0]      entry_y,
	input  logic [bti_pkg::XY_W-1:0]      query_x,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bti_pkg::VALUE_W-1:0]   value
);

	localparam int W      = bti_pkg::XY_W;
	localparam int VW     = bti_pkg::VALUE_W;
	localparam int DEPTH  = TABLES * ENTRIES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WIDE_W = ADDR_W + 3;
	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int N_W    = $clog2(ENTRIES + 1);

	bti_pkg::state_t state_q, state_d;

	// configuration
	logic                      model_valid_q;
	logic [VW-1:0]             torque_override_q;
	logic [bti_pkg::CNT_W-1:0] mag_count_q, time_count_q, torque_count_q;

	// transaction context
	logic [W-1:0]      x_q;
	logic [N_W-1:0]    n_q, n_d;
	logic [N_W-1:0]    idx_q, idx_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic              torque_q;
	logic [W-1:0]      prev_x_q, prev_y_q;
	logic [W-1:0]      y0_q, dy_q, dx_q, span_q;
	logic              neg_q;
	logic [VW-1:0]     value_q, value_d;

	// request decode
	logic                      accept;
	logic                      sel_ok;
	logic                      is_torque;
	logic                      short_path;
	logic [VW-1:0]             short_value;
	logic [bti_pkg::CNT_W-1:0] count_sel;
	logic [bti_pkg::CNT_W:0]   count_ext;
	logic [WIDE_W-1:0]         waddr_full;
	logic [WIDE_W-1:0]         base_full;
	logic                      mem_we;

	// scan datapath
	logic [2*W-1:0]    rd_data;
	logic [W-1:0]      rd_x, rd_y;
	logic [ADDR_W-1:0] rd_addr;
	logic              below_first;
	logic              in_seg;
	logic              last_entry;
	logic [VW-1:0]     clamp_value;
	logic              load_seg;
	logic              load_prev;

	bti_pkg::div_req_t div_req;
	bti_pkg::div_rsp_t div_rsp;

	assign accept = req_valid && !req_stall;
	assign sel_ok = {1'b0, table_sel} < (bti_pkg::SEL_W+1)'(TABLES);
	assign is_torque = table_sel == bti_pkg::SEL_TORQUE;

	always_comb begin
		case (table_sel)
			bti_pkg::SEL_MAG:  count_sel = mag_count_q;
			bti_pkg::SEL_TIME: count_sel = time_count_q;
			default:           count_sel = torque_count_q;
		endcase
	end

	// a count of zero acts as one, above the table size as the table size
	assign count_ext = {1'b0, count_sel};
	always_comb begin
		if (count_ext == '0) begin
			n_d = N_W'(1);
		end else if (count_ext > (bti_pkg::CNT_W+1)'(ENTRIES)) begin
			n_d = N_W'(ENTRIES);
		end else begin
			n_d = N_W'(count_ext);
		end
	end

	// answers that need no table read
	always_comb begin
		short_path  = 1'b1;
		short_value = '0;
		if (func == bti_pkg::FUNC_WRITE || !sel_ok) begin
			short_value = '0;
		end else if (is_torque && torque_override_q != '0) begin
			short_value = torque_override_q;
		end else if (!model_valid_q) begin
			short_value = is_torque ? VW'(0) : VW'(1);
		end else begin
			short_path = 1'b0;
		end
	end

	assign base_full  = WIDE_W'(table_sel) * WIDE_W'(ENTRIES);
	assign waddr_full = base_full + WIDE_W'(entry_index);
	assign mem_we     = accept && func == bti_pkg::FUNC_WRITE && sel_ok &&
		({2'b00, entry_index} < (bti_pkg::EIDX_W+2)'(ENTRIES));

	assign rd_x = rd_data[2*W-1:W];
	assign rd_y = rd_data[W-1:0];

	assign below_first = x_q < rd_x;
	assign in_seg      = x_q >= prev_x_q && x_q < rd_x;
	assign last_entry  = (idx_q + 1'b1) == n_q;
	assign clamp_value = torque_q ? {rd_y, 1'b0} : {1'b0, rd_y};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bti_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = short_path ? bti_pkg::ST_OUT : bti_pkg::ST_FIRST;
				end
			end
			bti_pkg::ST_FIRST: begin
				if (below_first || n_q == N_W'(1)) begin
					state_d = bti_pkg::ST_OUT;
				end else begin
					state_d = bti_pkg::ST_SCAN;
				end
			end
			bti_pkg::ST_SCAN: begin
				if (in_seg) begin
					state_d = bti_pkg::ST_DIVGO;
				end else if (last_entry) begin
					state_d = bti_pkg::ST_OUT;
				end
			end
			bti_pkg::ST_DIVGO: begin
				state_d = bti_pkg::ST_DIVRUN;
			end
			bti_pkg::ST_DIVRUN: begin
				if (div_rsp.done) begin
					state_d = bti_pkg::ST_OUT;
				end
			end
			bti_pkg::ST_OUT: begin
				if (!rsp_stall) begin
					state_d = bti_pkg::ST_IDLE;
				end
			end
			default: state_d = bti_pkg::ST_IDLE;
		endcase
	end

	// datapath controls; read data always belongs to entry idx_q
	always_comb begin
		idx_d     = idx_q;
		base_d    = base_q;
		value_d   = value_q;
		load_seg  = 1'b0;
		load_prev = 1'b0;
		case (state_q)
			bti_pkg::ST_IDLE: begin
				idx_d   = '0;
				base_d  = base_full[ADDR_W-1:0];
				value_d = short_value;
			end
			bti_pkg::ST_FIRST: begin
				load_prev = 1'b1;
				idx_d     = N_W'(1);
				value_d   = below_first ? {1'b0, rd_y} : clamp_value;
			end
			bti_pkg::ST_SCAN: begin
				value_d = clamp_value;
				if (in_seg) begin
					load_seg = 1'b1;
				end else if (!last_entry) begin
					load_prev = 1'b1;
					idx_d     = idx_q + 1'b1;
				end
			end
			bti_pkg::ST_DIVRUN: begin
				value_d = neg_q ? VW'({1'b0, y0_q} - {1'b0, div_rsp.quot}) :
					VW'({1'b0, y0_q} + {1'b0, div_rsp.quot});
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	assign rd_addr = base_d + ADDR_W'(idx_d[IDX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_valid_q     <= 1'b0;
			torque_override_q <= '0;
			mag_count_q       <= bti_pkg::CNT_W'(1);
			time_count_q      <= bti_pkg::CNT_W'(1);
			torque_count_q    <= bti_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				bti_pkg::CFG_MODEL_VALID:     model_valid_q     <= cfg_data[0];
				bti_pkg::CFG_TORQUE_OVERRIDE: torque_override_q <= cfg_data;
				bti_pkg::CFG_MAG_COUNT:       mag_count_q  <= cfg_data[bti_pkg::CNT_W-1:0];
				bti_pkg::CFG_TIME_COUNT:      time_count_q <= cfg_data[bti_pkg::CNT_W-1:0];
				bti_pkg::CFG_TORQUE_COUNT:    torque_count_q <= cfg_data[bti_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		base_q  <= base_d;
		value_q <= value_d;
		if (accept) begin
			x_q      <= query_x;
			n_q      <= n_d;
			torque_q <= is_torque;
		end
		if (load_prev) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
		end
		if (load_seg) begin
			y0_q   <= prev_y_q;
			neg_q  <= rd_y < prev_y_q;
			dy_q   <= (rd_y < prev_y_q) ? prev_y_q - rd_y : rd_y - prev_y_q;
			dx_q   <= x_q - prev_x_q;
			span_q <= rd_x - prev_x_q;
		end
	end

	bti_mem #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr_full[ADDR_W-1:0]),
		.wdata({entry_x, entry_y}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign div_req.start = state_q == bti_pkg::ST_DIVGO;
	assign div_req.dy    = dy_q;
	assign div_req.dx    = dx_q;
	assign div_req.span  = span_q;

	bti_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign req_stall = state_q != bti_pkg::ST_IDLE;
	assign rsp_valid = state_q == bti_pkg::ST_OUT;
	assign value     = value_q;

	// a write transaction answers zero on the following cycle
	a_write_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == bti_pkg::FUNC_WRITE |=> rsp_valid && value == '0)
		else $error("write transaction did not answer zero");

	// divider completion only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == bti_pkg::ST_DIVRUN)
		else $error("divider finished outside its wait state");

	// the scan never passes the last used breakpoint
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bti_pkg::ST_SCAN |-> idx_q < n_q && idx_q != '0)
		else $error("breakpoint scan out of range");

	// a pending response holds off the next request
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request accepted while response pending");

endmodule
